// ----- hw/rtl/modbus_rtu_response_checker_top_assert.svh -----
// Assertion macros for the Modbus RTU response checker.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef MODBUS_RTU_RESPONSE_CHECKER_TOP_ASSERT_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_TOP_ASSERT_SVH

// same-cycle implication
`define MRC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/mrc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the Modbus RTU response checker.
// No dependencies.
package mrc_pkg;

    localparam int RX_BYTE_W   = 8;
    localparam int REG_WORD_W  = 16;
    localparam int REG_INDEX_W = 5;
    localparam int STATUS_W    = 3;
    localparam int PAYLOAD_W   = 6;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int CRC_W       = 16;
    localparam int BIT_STEPS   = 8;
    localparam int WORD_DEPTH  = 29;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SLAVE_ADDRESS     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_FUNCTION = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAYLOAD_BYTES     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RETURN_REGISTERS  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRC_LOW_ONLY      = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 3'd0,
        STAT_TIMEOUT = 3'd1,
        STAT_ADDR    = 3'd2,
        STAT_FUNC    = 3'd3,
        STAT_CRC     = 3'd4
    } frame_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CRC,
        ST_READ,
        ST_WORD,
        ST_STATUS
    } mrc_state_t;

    typedef struct packed {
        logic start;
        logic clear;
    } crc_ctrl_t;

    typedef struct packed {
        logic             busy;
        logic [CRC_W-1:0] value;
    } crc_stat_t;

endpackage

// ----- hw/rtl/mrc_if.sv -----
`timescale 1ns / 1ps
// Channel interfaces: received bytes, results, configuration writes.
// Depends on mrc_pkg.
interface mrc_rx_if;
    import mrc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [RX_BYTE_W-1:0] rx_byte;
    logic                 timed_out;
    modport source (output valid, rx_byte, timed_out, input ready);
    modport sink   (input valid, rx_byte, timed_out, output ready);
endinterface

interface mrc_res_if;
    import mrc_pkg::*;
    logic                   valid;
    logic                   ready;
    logic                   result_kind;
    logic [REG_WORD_W-1:0]  register_word;
    logic [REG_INDEX_W-1:0] register_index;
    logic [STATUS_W-1:0]    frame_status;
    logic                   last_result;
    modport source (output valid, result_kind, register_word, register_index,
                    frame_status, last_result, input ready);
    modport sink   (input valid, result_kind, register_word, register_index,
                    frame_status, last_result, output ready);
endinterface

interface mrc_cfg_if;
    import mrc_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/modbus_rtu_response_checker_top.sv -----
`timescale 1ns / 1ps
// Modbus RTU response checker, top level. Depends on mrc_pkg, mrc_if, mrc_crc_serial, mrc_ram.
// A byte before the CRC field goes through accept, 8 serial CRC steps and return to idle;
// a CRC byte is taken in idle. A frame-ending byte or timeout gives its status from the
// status state once the output register is free; in register mode each word passes a
// read and a word state (registered RAM read). Reset restores the configuration defaults
// and clears frame state; stored words stay undefined.
module modbus_rtu_response_checker_top #(
    parameter int FRAME_BUFFER_BYTES = 64
) (
    input  logic    clk,
    input  logic    rst_n,
    mrc_rx_if.sink  rx,
    mrc_res_if.source result,
    mrc_cfg_if.sink cfg
);
    import mrc_pkg::*;

    localparam int PLEN_LIMIT = FRAME_BUFFER_BYTES - 4;
    localparam int PLEN_FIELD_MAX = (1 << PAYLOAD_W) - 1;
    localparam logic [PAYLOAD_W-1:0] PLEN_CAP =
        (PLEN_LIMIT > PLEN_FIELD_MAX) ? PAYLOAD_W'(PLEN_FIELD_MAX) : PAYLOAD_W'(PLEN_LIMIT);
    localparam logic [REG_INDEX_W-1:0] WORD_CAP = REG_INDEX_W'(WORD_DEPTH);

    // configuration
    logic [7:0]           slave_address_reg;
    logic [7:0]           expected_function_reg;
    logic [PAYLOAD_W-1:0] payload_bytes_reg;
    logic                 return_registers_reg;
    logic                 crc_low_only_reg;

    // frame state
    mrc_state_t             state_reg, state_next;
    logic [PAYLOAD_W-1:0]   pos_reg;
    logic [RX_BYTE_W-1:0]   rcv_low_reg;
    logic                   addr_ok_reg;
    logic                   func_ok_reg;
    logic [RX_BYTE_W-1:0]   hold_reg;
    frame_status_t          status_reg;
    logic [REG_INDEX_W-1:0] nwords_reg;
    logic [REG_INDEX_W-1:0] word_idx_reg;

    // output register
    logic                   out_valid_reg;
    logic                   out_kind_reg;
    logic [REG_WORD_W-1:0]  out_word_reg;
    logic [REG_INDEX_W-1:0] out_index_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic                   out_last_reg;

    crc_ctrl_t crc_ctrl;
    crc_stat_t crc_stat;

    logic                   rx_ready_w;
    logic                   rx_fire;
    logic                   out_free;
    logic                   load_word;
    logic                   load_status;
    logic [PAYLOAD_W-1:0]   plen;
    logic [PAYLOAD_W:0]     crc_pos;
    logic [PAYLOAD_W:0]     last_pos;
    logic                   in_frame;
    logic                   in_body;
    logic [PAYLOAD_W-1:0]   k;
    logic [REG_INDEX_W-1:0] store_idx;
    logic                   payload_byte;
    logic                   word_wr;
    logic                   hold_wr;
    logic [PAYLOAD_W-1:0]   plen_m1;
    logic [REG_INDEX_W-1:0] nwords_raw;
    logic [REG_INDEX_W-1:0] nwords_calc;
    frame_status_t          judge_status;
    logic [REG_WORD_W-1:0]  rd_data;

    assign rx_fire  = rx.valid && rx_ready_w;
    assign out_free = !out_valid_reg || result.ready;

    // byte classification against the current registers
    always_comb
    begin
        plen      = (payload_bytes_reg > PLEN_CAP) ? PLEN_CAP : payload_bytes_reg;
        crc_pos   = {1'b0, plen} + (PAYLOAD_W+1)'(2);
        last_pos  = crc_pos + {{PAYLOAD_W{1'b0}}, ~crc_low_only_reg};
        in_frame  = {1'b0, pos_reg} < last_pos;
        in_body   = {1'b0, pos_reg} < crc_pos;
        k         = pos_reg - PAYLOAD_W'(2);
        store_idx = k[PAYLOAD_W-1:1] - REG_INDEX_W'(1);
        payload_byte = rx_fire && !rx.timed_out && in_frame && in_body
                    && (pos_reg >= PAYLOAD_W'(2));
        hold_wr   = payload_byte && k[0];
        word_wr   = payload_byte && !k[0] && (k != '0) && (store_idx < WORD_CAP);

        plen_m1    = plen - PAYLOAD_W'(1);
        nwords_raw = (plen == '0) ? '0 : plen_m1[PAYLOAD_W-1:1];
        nwords_calc = (nwords_raw > WORD_CAP) ? WORD_CAP : nwords_raw;

        if (!addr_ok_reg)
            judge_status = STAT_ADDR;
        else if (!func_ok_reg)
            judge_status = STAT_FUNC;
        else if (crc_low_only_reg)
            judge_status = (rx.rx_byte == crc_stat.value[7:0]) ? STAT_OK : STAT_CRC;
        else
            judge_status = ({rx.rx_byte, rcv_low_reg} == crc_stat.value) ? STAT_OK : STAT_CRC;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (rx_fire)
                begin
                    if (rx.timed_out)
                        state_next = ST_STATUS;
                    else if (in_frame)
                        state_next = in_body ? ST_CRC : ST_IDLE;
                    else if (judge_status == STAT_OK && return_registers_reg
                             && nwords_calc != '0)
                        state_next = ST_READ;
                    else
                        state_next = ST_STATUS;
                end
            end
            ST_CRC:
                if (!crc_stat.busy)
                    state_next = ST_IDLE;
            ST_READ:
                state_next = ST_WORD;
            ST_WORD:
            begin
                if (out_free)
                    state_next = (word_idx_reg + REG_INDEX_W'(1) == nwords_reg) ?
                                 ST_STATUS : ST_READ;
            end
            ST_STATUS:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb
    begin
        rx_ready_w     = (state_reg == ST_IDLE);
        crc_ctrl.start = (state_reg == ST_IDLE) && rx_fire && !rx.timed_out
                      && in_frame && in_body;
        crc_ctrl.clear = (state_reg == ST_IDLE) && rx_fire && (rx.timed_out || !in_frame);
        load_word      = (state_reg == ST_WORD) && out_free;
        load_status    = (state_reg == ST_STATUS) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            rcv_low_reg  <= '0;
            addr_ok_reg  <= 1'b0;
            func_ok_reg  <= 1'b0;
            hold_reg     <= '0;
            status_reg   <= STAT_OK;
            nwords_reg   <= '0;
            word_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (rx_fire)
            begin
                if (rx.timed_out || !in_frame)
                begin
                    // frame ends: judged or aborted
                    pos_reg      <= '0;
                    rcv_low_reg  <= '0;
                    addr_ok_reg  <= 1'b0;
                    func_ok_reg  <= 1'b0;
                    hold_reg     <= '0;
                    status_reg   <= rx.timed_out ? STAT_TIMEOUT : judge_status;
                    nwords_reg   <= nwords_calc;
                    word_idx_reg <= '0;
                end
                else
                begin
                    pos_reg <= pos_reg + PAYLOAD_W'(1);
                    if (!in_body)
                        rcv_low_reg <= rx.rx_byte;
                    if (pos_reg == PAYLOAD_W'(0))
                        addr_ok_reg <= (rx.rx_byte == slave_address_reg);
                    if (pos_reg == PAYLOAD_W'(1) && in_body)
                        func_ok_reg <= (rx.rx_byte == expected_function_reg);
                    if (hold_wr)
                        hold_reg <= rx.rx_byte;
                end
            end
            else if (load_word)
                word_idx_reg <= word_idx_reg + REG_INDEX_W'(1);
        end
    end

    // configuration registers; writes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg     <= 8'd1;
            expected_function_reg <= 8'd3;
            payload_bytes_reg     <= PAYLOAD_W'(5);
            return_registers_reg  <= 1'b1;
            crc_low_only_reg      <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_SLAVE_ADDRESS:     slave_address_reg     <= cfg.data;
                CFG_EXPECTED_FUNCTION: expected_function_reg <= cfg.data;
                CFG_PAYLOAD_BYTES:     payload_bytes_reg     <= cfg.data[PAYLOAD_W-1:0];
                CFG_RETURN_REGISTERS:  return_registers_reg  <= cfg.data[0];
                CFG_CRC_LOW_ONLY:      crc_low_only_reg      <= cfg.data[0];
                default:               ;
            endcase
        end
    end

    assign cfg.ready = 1'b1;
    assign rx.ready  = rx_ready_w;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_word || load_status)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_word)
        begin
            out_kind_reg   <= 1'b0;
            out_word_reg   <= rd_data;
            out_index_reg  <= word_idx_reg;
            out_status_reg <= STAT_OK;
            out_last_reg   <= 1'b0;
        end
        else if (load_status)
        begin
            out_kind_reg   <= 1'b1;
            out_word_reg   <= '0;
            out_index_reg  <= '0;
            out_status_reg <= status_reg;
            out_last_reg   <= 1'b1;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.result_kind    = out_kind_reg;
    assign result.register_word  = out_word_reg;
    assign result.register_index = out_index_reg;
    assign result.frame_status   = out_status_reg;
    assign result.last_result    = out_last_reg;

    mrc_crc_serial u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (crc_ctrl),
        .data  (rx.rx_byte),
        .stat  (crc_stat)
    );

    mrc_ram #(
        .WIDTH (REG_WORD_W),
        .DEPTH (WORD_DEPTH)
    ) u_word_store (
        .clk   (clk),
        .we    (word_wr),
        .waddr (store_idx),
        .wdata ({hold_reg, rx.rx_byte}),
        .raddr (word_idx_reg),
        .rdata (rd_data)
    );

endmodule

// ----- hw/rtl/mrc_crc_serial.sv -----
`timescale 1ns / 1ps
// Bit-serial CRC-16/Modbus accumulator, one data bit per cycle, LSB first.
// Depends on mrc_pkg.
module mrc_crc_serial (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mrc_pkg::crc_ctrl_t            ctrl,
    input  logic [mrc_pkg::RX_BYTE_W-1:0] data,
    output mrc_pkg::crc_stat_t            stat
);
    import mrc_pkg::*;

    localparam logic [2:0] LAST_STEP = 3'(BIT_STEPS - 1);

    logic [CRC_W-1:0]     crc_reg;
    logic [CRC_W-1:0]     crc_next;
    logic [RX_BYTE_W-1:0] data_reg;
    logic [2:0]           cnt_reg;
    logic                 busy_reg;

    // feeding data bits one by one is equivalent to xoring the byte up front
    assign crc_next = {1'b0, crc_reg[CRC_W-1:1]}
                    ^ ((crc_reg[0] ^ data_reg[0]) ? CRC_POLY : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= CRC_INIT;
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctrl.clear)
        begin
            crc_reg  <= CRC_INIT;
            busy_reg <= 1'b0;
        end
        else if (ctrl.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            crc_reg <= crc_next;
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == LAST_STEP)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
            data_reg <= data;
        else if (busy_reg)
            data_reg <= {1'b0, data_reg[RX_BYTE_W-1:1]};
    end

    assign stat.busy  = busy_reg;
    assign stat.value = crc_reg;

endmodule

// ----- hw/rtl/mrc_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mrc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 29
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/mrc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the response checker, bound to the top level.
// Depends on mrc_pkg and modbus_rtu_response_checker_top_assert.svh.
`include "modbus_rtu_response_checker_top_assert.svh"

module mrc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             rx_valid,
    input logic                             rx_ready,
    input logic                             rx_timed_out,
    input logic                             res_valid,
    input logic                             res_ready,
    input logic                             res_kind,
    input logic [mrc_pkg::REG_WORD_W-1:0]   res_word,
    input logic [mrc_pkg::REG_INDEX_W-1:0]  res_index,
    input logic [mrc_pkg::STATUS_W-1:0]     res_status,
    input logic                             res_last
);
    import mrc_pkg::*;

    `MRC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_kind) && $stable(res_word) && $stable(res_index) && $stable(res_status) && $stable(res_last), "result changed while stalled")
    `MRC_ASSERT_SAME(a_word_form, res_valid && !res_kind, !res_last && res_status == STAT_OK && res_index < WORD_DEPTH, "malformed word result")
    `MRC_ASSERT_SAME(a_status_form, res_valid && res_kind, res_last && res_word == '0 && res_index == '0, "malformed status result")
    `MRC_ASSERT_NEXT(a_tmo_busy, rx_valid && rx_ready && rx_timed_out, !rx_ready, "byte taken while timeout status pending")

endmodule

bind modbus_rtu_response_checker_top mrc_checker u_mrc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_valid     (rx.valid),
    .rx_ready     (rx.ready),
    .rx_timed_out (rx.timed_out),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_kind     (result.result_kind),
    .res_word     (result.register_word),
    .res_index    (result.register_index),
    .res_status   (result.frame_status),
    .res_last     (result.last_result)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for modbus_rtu_response_checker_top: frames, timeouts, config and stalls.
// Depends on mrc_pkg, mrc_if and the RTL; a local response predictor checks every result.
module tb_top;
    import mrc_pkg::*;

    localparam int BUF_BYTES     = 64;
    localparam int ITEM_TARGET   = 480;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 24;
    localparam int PRINT_LIMIT   = 40;

    typedef enum int {
        FLAW_NONE,
        FLAW_ADDR,
        FLAW_FUNC,
        FLAW_CRC,
        FLAW_TIMEOUT,
        FLAW_SHORT
    } flaw_t;

    typedef struct {
        logic                   kind;
        logic [REG_WORD_W-1:0]  word;
        logic [REG_INDEX_W-1:0] index;
        frame_status_t          status;
        logic                   last;
    } reply_t;

    logic clk = 1'b0;
    logic rst_n;

    mrc_rx_if  rx_ch ();
    mrc_res_if res_ch ();
    mrc_cfg_if cfg_ch ();

    modbus_rtu_response_checker_top #(
        .FRAME_BUFFER_BYTES(BUF_BYTES)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // register mirror
    logic [7:0]           cfg_slave;
    logic [7:0]           cfg_func;
    logic [PAYLOAD_W-1:0] cfg_payload;
    logic                 cfg_regs;
    logic                 cfg_crc_low;

    // frame tracking
    logic [PAYLOAD_W-1:0]  rx_pos;
    logic [CRC_W-1:0]      run_crc;
    logic [7:0]            crc_low_seen;
    logic                  addr_hit;
    logic                  func_hit;
    logic [7:0]            word_high;
    logic [REG_WORD_W-1:0] reg_words [WORD_DEPTH];

    reply_t pending_replies [$];

    int unsigned items_sent;
    int unsigned replies_checked;
    int unsigned cfg_writes;
    int unsigned mismatches;
    int unsigned quiet_cycles;
    int unsigned status_tally [5];

    bit src_gaps_on;
    bit sink_gaps_on;
    int hold_request;
    int sink_wait;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 8'h00;
        else if (r < 30)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic logic [CRC_W-1:0] crc16_step(input logic [CRC_W-1:0] crc,
                                                    input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    task automatic frame_restart();
        rx_pos       = '0;
        run_crc      = CRC_INIT;
        crc_low_seen = '0;
        addr_hit     = 1'b0;
        func_hit     = 1'b0;
        word_high    = '0;
    endtask

    task automatic push_word(input int unsigned idx, input logic [REG_WORD_W-1:0] w);
        reply_t rp;
        rp.kind   = 1'b0;
        rp.word   = w;
        rp.index  = REG_INDEX_W'(idx);
        rp.status = STAT_OK;
        rp.last   = 1'b0;
        pending_replies.push_back(rp);
    endtask

    task automatic push_status(input frame_status_t st);
        reply_t rp;
        rp.kind   = 1'b1;
        rp.word   = '0;
        rp.index  = '0;
        rp.status = st;
        rp.last   = 1'b1;
        pending_replies.push_back(rp);
        status_tally[st]++;
    endtask

    // Advance the frame by one accepted byte and queue whatever it produces.
    task automatic judge_rx_byte(input logic [7:0] b, input logic tmo);
        int unsigned   plen;
        int unsigned   crc_at;
        int unsigned   last_at;
        int unsigned   k;
        int unsigned   idx;
        int unsigned   n_words;
        frame_status_t st;
        if (tmo)
        begin
            frame_restart();
            push_status(STAT_TIMEOUT);
            return;
        end
        plen = cfg_payload;
        if (plen > BUF_BYTES - 4)
            plen = BUF_BYTES - 4;
        crc_at  = 2 + plen;
        last_at = crc_at + (cfg_crc_low ? 0 : 1);
        if (rx_pos < last_at)
        begin
            if (rx_pos < crc_at)
            begin
                run_crc = crc16_step(run_crc, b);
                if (rx_pos == 0)
                    addr_hit = (b == cfg_slave);
                else if (rx_pos == 1)
                    func_hit = (b == cfg_func);
                else
                begin
                    k = rx_pos - 2;
                    // payload byte 0 is the byte count, then high/low pairs
                    if (k >= 1)
                    begin
                        if (k % 2 == 1)
                            word_high = b;
                        else
                        begin
                            idx = (k - 2) / 2;
                            if (idx < WORD_DEPTH)
                                reg_words[idx] = {word_high, b};
                        end
                    end
                end
            end
            else
                crc_low_seen = b;
            rx_pos = rx_pos + 1'b1;
            return;
        end
        if (!addr_hit)
            st = STAT_ADDR;
        else if (!func_hit)
            st = STAT_FUNC;
        else if (cfg_crc_low)
            st = (b == run_crc[7:0]) ? STAT_OK : STAT_CRC;
        else
            st = ({b, crc_low_seen} == run_crc) ? STAT_OK : STAT_CRC;
        if (st == STAT_OK && cfg_regs)
        begin
            n_words = (plen >= 1) ? (plen - 1) / 2 : 0;
            if (n_words > WORD_DEPTH)
                n_words = WORD_DEPTH;
            for (int i = 0; i < n_words; i++)
                push_word(i, reg_words[i]);
        end
        push_status(st);
        frame_restart();
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            replies_checked++;
            if (pending_replies.size() == 0)
                report_mismatch("unexpected result, kind", res_ch.result_kind, 0);
            else
            begin
                want = pending_replies.pop_front();
                if (res_ch.result_kind !== want.kind)
                    report_mismatch("result_kind", res_ch.result_kind, want.kind);
                if (res_ch.register_word !== want.word)
                    report_mismatch("register_word", res_ch.register_word, want.word);
                if (res_ch.register_index !== want.index)
                    report_mismatch("register_index", res_ch.register_index, want.index);
                if (res_ch.frame_status !== want.status)
                    report_mismatch("frame_status", res_ch.frame_status, want.status);
                if (res_ch.last_result !== want.last)
                    report_mismatch("last_result", res_ch.last_result, want.last);
            end
        end
    end

    // result side; a hold request keeps ready low until its requested wait has counted down
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            sink_wait    = hold_request;
            hold_request = 0;
        end
        if (sink_wait > 0)
        begin
            res_ch.ready = 1'b0;
            sink_wait--;
        end
        else if (sink_gaps_on && $urandom_range(0, 99) < 20)
        begin
            res_ch.ready = 1'b0;
            sink_wait    = pick_gap() - 1;
        end
        else
            res_ch.ready = 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                         quiet_cycles, pending_replies.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic push_rx(input logic [7:0] b, input logic tmo);
        @(negedge clk);
        if (src_gaps_on && $urandom_range(0, 99) < 25)
        begin
            rx_ch.valid = 1'b0;
            repeat (pick_gap()) @(negedge clk);
        end
        rx_ch.rx_byte   = b;
        rx_ch.timed_out = tmo;
        rx_ch.valid     = 1'b1;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        items_sent++;
        judge_rx_byte(b, tmo);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        rx_ch.valid = 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
        wait_drained();
        // a byte may still be in its serial CRC steps
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        cfg_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_writes++;
        case (idx)
            CFG_SLAVE_ADDRESS:     cfg_slave   = value;
            CFG_EXPECTED_FUNCTION: cfg_func    = value;
            CFG_PAYLOAD_BYTES:     cfg_payload = value[PAYLOAD_W-1:0];
            CFG_RETURN_REGISTERS:  cfg_regs    = value[0];
            CFG_CRC_LOW_ONLY:      cfg_crc_low = value[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Build one response for the current settings, optionally damaged, and send it.
    task automatic send_frame(input flaw_t flaw);
        logic [7:0]       frame_q [$];
        logic [CRC_W-1:0] crc;
        int unsigned      n_words;
        int unsigned      cut;
        n_words = (cfg_payload >= 1) ? (cfg_payload - 1) / 2 : 0;
        frame_q.push_back(flaw == FLAW_ADDR ? cfg_slave ^ 8'($urandom_range(1, 255)) : cfg_slave);
        frame_q.push_back(flaw == FLAW_FUNC ? cfg_func ^ 8'($urandom_range(1, 255)) : cfg_func);
        for (int k = 0; k < cfg_payload; k++)
            frame_q.push_back((k == 0 && cfg_regs) ? 8'(2 * n_words) : pick_byte());
        crc = CRC_INIT;
        foreach (frame_q[i])
            crc = crc16_step(crc, frame_q[i]);
        if (flaw == FLAW_CRC)
            crc ^= cfg_crc_low ? CRC_W'(1 << $urandom_range(0, 7))
                               : CRC_W'(1 << $urandom_range(0, 15));
        frame_q.push_back(crc[7:0]);
        if (!cfg_crc_low)
            frame_q.push_back(crc[15:8]);
        cut = frame_q.size();
        if (flaw == FLAW_SHORT)
            cut--;
        else if (flaw == FLAW_TIMEOUT)
            cut = $urandom_range(0, frame_q.size() - 1);
        for (int i = 0; i < cut; i++)
            push_rx(frame_q[i], 1'b0);
        if (flaw == FLAW_TIMEOUT)
            push_rx(8'($urandom), 1'b1);
    endtask

    task automatic test_default_frame();
        // reset settings: address 1, function 3, five payload bytes, two words
        send_frame(FLAW_NONE);
        push_rx(8'hFF, 1'b1);
        wait_drained();
    endtask

    task automatic test_frame_checks();
        write_reg(CFG_PAYLOAD_BYTES, 8'd0);
        send_frame(FLAW_ADDR);
        send_frame(FLAW_FUNC);
        send_frame(FLAW_CRC);
        wait_drained();
    endtask

    task automatic test_max_response();
        // 59 payload bytes: 29 words plus status, fills every store entry
        write_reg(CFG_SLAVE_ADDRESS, 8'hFF);
        write_reg(CFG_EXPECTED_FUNCTION, 8'h00);
        write_reg(CFG_PAYLOAD_BYTES, 8'd59);
        write_reg(CFG_RETURN_REGISTERS, 8'd1);
        write_reg(CFG_CRC_LOW_ONLY, 8'd0);
        send_frame(FLAW_NONE);
        wait_drained();
    endtask

    task automatic test_backpressure();
        write_reg(CFG_PAYLOAD_BYTES, 8'd20);
        hold_request = 400;
        repeat (3) send_frame(FLAW_NONE);
        repeat (10) push_rx(8'($urandom), 1'b1);
        wait_drained();
        hold_request = 300;
        repeat (16) push_rx(8'($urandom), 1'b1);
        wait_drained();
    endtask

    task automatic test_midframe_config();
        write_reg(CFG_PAYLOAD_BYTES, 8'd10);
        push_rx(cfg_slave, 1'b0);
        push_rx(cfg_func, 1'b0);
        repeat (5) push_rx(pick_byte(), 1'b0);
        // shrink past the current position: the next byte closes the frame
        write_reg(CFG_PAYLOAD_BYTES, 8'd2);
        push_rx(pick_byte(), 1'b0);
        push_rx(cfg_slave, 1'b0);
        push_rx(cfg_func, 1'b0);
        repeat (3) push_rx(pick_byte(), 1'b0);
        write_reg(CFG_PAYLOAD_BYTES, 8'd8);
        write_reg(CFG_CRC_LOW_ONLY, 8'd1);
        repeat (6) push_rx(pick_byte(), 1'b0);
        push_rx(8'($urandom), 1'b1);
        wait_drained();
    endtask

    task automatic test_random_phases();
        int r;
        while (items_sent < ITEM_TARGET)
        begin
            src_gaps_on  = $urandom_range(0, 3) != 0;
            sink_gaps_on = $urandom_range(0, 3) != 0;
            write_reg(CFG_SLAVE_ADDRESS, pick_byte());
            write_reg(CFG_EXPECTED_FUNCTION, pick_byte());
            r = $urandom_range(0, 99);
            if (r < 45)
                write_reg(CFG_PAYLOAD_BYTES, 8'($urandom_range(0, 4)));
            else if (r < 85)
                write_reg(CFG_PAYLOAD_BYTES, 8'($urandom_range(5, 16)));
            else if (r < 95)
                write_reg(CFG_PAYLOAD_BYTES, 8'($urandom_range(17, 58)));
            else
                write_reg(CFG_PAYLOAD_BYTES, 8'd59);
            write_reg(CFG_RETURN_REGISTERS, 8'($urandom_range(0, 1)));
            write_reg(CFG_CRC_LOW_ONLY, 8'($urandom_range(0, 1)));
            repeat ($urandom_range(3, 8))
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    send_frame(FLAW_NONE);
                else if (r < 76)
                    send_frame(FLAW_ADDR);
                else if (r < 82)
                    send_frame(FLAW_FUNC);
                else if (r < 88)
                    send_frame(FLAW_CRC);
                else if (r < 93)
                    send_frame(FLAW_TIMEOUT);
                else if (r < 96)
                    send_frame(FLAW_SHORT);
                else
                    repeat ($urandom_range(1, 4))
                        push_rx(8'($urandom), $urandom_range(0, 9) == 0);
            end
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        rx_ch.valid     = 1'b0;
        rx_ch.rx_byte   = '0;
        rx_ch.timed_out = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;
        res_ch.ready    = 1'b0;
        hold_request    = 0;
        sink_wait       = 0;
        src_gaps_on     = 1'b1;
        sink_gaps_on    = 1'b1;
        items_sent      = 0;
        replies_checked = 0;
        cfg_writes      = 0;
        mismatches      = 0;
        quiet_cycles    = 0;
        foreach (status_tally[i])
            status_tally[i] = 0;
        cfg_slave   = 8'd1;
        cfg_func    = 8'd3;
        cfg_payload = 6'd5;
        cfg_regs    = 1'b1;
        cfg_crc_low = 1'b0;
        frame_restart();
        foreach (reg_words[i])
            reg_words[i] = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_default_frame();
        test_frame_checks();
        test_max_response();
        test_backpressure();
        test_midframe_config();
        test_random_phases();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d bytes and timeouts over %0d register writes; checked %0d results.",
                 items_sent, cfg_writes, replies_checked);
        $display("Statuses: %0d ok, %0d timeout, %0d address, %0d function, %0d CRC.",
                 status_tally[0], status_tally[1], status_tally[2], status_tally[3],
                 status_tally[4]);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
